// ===== design/sorted_periodic_timer_queue_top_assert.svh =====
// Assertion macros used by the checker of the timer queue.
`ifndef SORTED_PERIODIC_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_PERIODIC_TIMER_QUEUE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// Shared types, widths and codes of the sorted periodic timer queue.
package spq_pkg;

    // Sizes of the timer table and of the fields.
    localparam int TIMERS      = 32;
    localparam int TIME_BITS   = 48;
    localparam int PERIOD_BITS = 31;
    localparam int HANDLE_BITS = 5;
    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 3;
    localparam int IDX_BITS    = $clog2(TIMERS);
    localparam int LEN_BITS    = $clog2(TIMERS + 1);

    // Stream packing of the input and output transfers.
    localparam int NOW_LSB      = 0;
    localparam int INTERVAL_LSB = NOW_LSB + TIME_BITS;
    localparam int HANDLE_LSB   = INTERVAL_LSB + PERIOD_BITS;
    localparam int FINISHED_LSB = HANDLE_LSB + HANDLE_BITS;
    localparam int IN_TDATA_W   = ((FINISHED_LSB + 1 + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((HANDLE_BITS + 7) / 8) * 8;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_MIN_INTERVAL = 1'b0;
    localparam logic [PERIOD_BITS-1:0] MIN_INTERVAL_RESET = PERIOD_BITS'(5);

    // Action codes.
    localparam logic [ACTION_BITS-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_POLL   = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_RETURN = 2'd2;
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR  = 2'd3;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_TOO_SMALL = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_DUE   = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_NOT_OUT   = 3'd4;

    typedef logic [TIME_BITS-1:0]   t_time;
    typedef logic [PERIOD_BITS-1:0] t_period;
    typedef logic [IDX_BITS-1:0]    t_idx;
    typedef logic [LEN_BITS-1:0]    t_len;

    // One accepted request.
    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        t_time                  now_ms;
        t_period                interval_ms;
        logic [HANDLE_BITS-1:0] handle;
        logic                   finished;
    } t_item;

    // One result transfer.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [HANDLE_BITS-1:0] handle_out;
    } t_result;

    // Entry of the sorted list: trigger time kept beside the slot number.
    typedef struct packed {
        t_time trig;
        t_idx  slot;
    } t_ord_entry;

    // Entry of the per-slot table.
    typedef struct packed {
        t_period period;
        t_time   trig;
    } t_slot_entry;

endpackage

// ===== design/sorted_periodic_timer_queue_top.sv =====
// Top level of the sorted periodic timer queue: stream ports, register port, result register.
//
// Requests enter on the s_axis channel, one transfer per request: tuser holds the
// action (add, poll, return, clear), tdata the time, interval, handle and finished flag.
// Every request gives exactly one result on the m_axis channel: tuser holds the status,
// tdata the handle. The register min_interval is written through the APB port at
// byte address 0 and may be changed only while no request is in progress.
// Requests are handled one at a time. A clear, a too-small add and a return that is
// refused or frees its timer are settled in the dispatch state; a poll on an empty
// list likewise, else it reads the head entry and, if that timer fired, its slot entry.
// An add scans the slot flags one per cycle and then walks the sorted list from its
// tail, one entry per cycle; a return that requeues reads its slot entry and then
// walks the list the same way. The slot scan and the walk set how long these take.
// The next request is accepted at the earliest at the edge where the previous result
// can first transfer, so no new request is taken before the last result is registered.
// Reset empties the queue, frees every slot and sets min_interval to 5; the memories
// themselves are not cleared. A finished result waits in an output register, so the
// next request is taken while the receiver stalls; that request then holds in its
// last cycle until the output register is free.
module sorted_periodic_timer_queue_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // now_ms [47:0], interval_ms [78:48], handle [83:79], finished [84], zero pad
    input  logic [spq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action [1:0]
    input  logic [spq_pkg::ACTION_BITS-1:0]    s_axis_tuser,
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // handle_out [4:0], zero pad
    output logic [spq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status [2:0]
    output logic [spq_pkg::STATUS_BITS-1:0]    m_axis_tuser,
    // Register port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spq_pkg::PADDR_W-1:0]        paddr,
    input  logic [spq_pkg::PDATA_W-1:0]        pwdata,
    output logic [spq_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);

    logic [spq_pkg::PERIOD_BITS-1:0] r_min_interval;
    logic                            r_m_valid;
    spq_pkg::t_result                r_m_res;
    spq_pkg::t_item                  item;
    spq_pkg::t_result                res;
    logic                            res_valid;
    logic                            res_ready;
    logic                            reg_hit;

    // Register port: writes in the access phase, reads straight from the register.
    assign pready  = 1'b1;
    assign reg_hit = (paddr[spq_pkg::PADDR_W-1:2] == spq_pkg::REG_MIN_INTERVAL);
    assign prdata  = reg_hit ? spq_pkg::PDATA_W'(r_min_interval) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= spq_pkg::MIN_INTERVAL_RESET;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_min_interval <= pwdata[spq_pkg::PERIOD_BITS-1:0];
        end
    end

    // Unpack the request transfer.
    always_comb begin
        item.action      = s_axis_tuser;
        item.now_ms      = s_axis_tdata[spq_pkg::NOW_LSB +: spq_pkg::TIME_BITS];
        item.interval_ms = s_axis_tdata[spq_pkg::INTERVAL_LSB +: spq_pkg::PERIOD_BITS];
        item.handle      = s_axis_tdata[spq_pkg::HANDLE_LSB +: spq_pkg::HANDLE_BITS];
        item.finished    = s_axis_tdata[spq_pkg::FINISHED_LSB];
    end

    spq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (s_axis_tvalid),
        .o_item_ready   (s_axis_tready),
        .i_item         (item),
        .i_min_interval (r_min_interval),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res)
    );

    // Output register: loads when empty or when its transfer completes.
    assign res_ready = res_valid && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready) begin
            r_m_res <= res;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = spq_pkg::OUT_TDATA_W'(r_m_res.handle_out);
    assign m_axis_tuser  = r_m_res.status;

endmodule

// ===== design/spq_ram.sv =====
// Simple dual-port synchronous RAM with a registered read port.
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/spq_ctrl.sv =====
// Sequencer of the timer queue: slot table, sorted circular list and their updates.
module spq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    output logic                          o_item_ready,
    input  spq_pkg::t_item                i_item,
    input  logic [spq_pkg::PERIOD_BITS-1:0] i_min_interval,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output spq_pkg::t_result              o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_POLL1 = 3'd3;
    localparam logic [2:0] S_POLL2 = 3'd4;
    localparam logic [2:0] S_RET   = 3'd5;
    localparam logic [2:0] S_WALK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    localparam spq_pkg::t_idx LAST_IDX = spq_pkg::IDX_BITS'(spq_pkg::TIMERS - 1);

    logic [2:0]                 r_state, n_state;
    spq_pkg::t_item             r_item, n_item;
    spq_pkg::t_len              r_len, n_len;
    spq_pkg::t_idx              r_head, n_head;
    logic [spq_pkg::TIMERS-1:0] r_busy, n_busy;
    logic [spq_pkg::TIMERS-1:0] r_out, n_out;
    spq_pkg::t_idx              r_idx, n_idx;
    spq_pkg::t_time             r_t, n_t;
    spq_pkg::t_idx              r_slot, n_slot;
    spq_pkg::t_idx              r_wp, n_wp;
    spq_pkg::t_idx              r_rp, n_rp;
    spq_pkg::t_len              r_rcnt, n_rcnt;
    logic                       r_dv, n_dv;
    spq_pkg::t_result           r_res, n_res;

    logic                        ord_we, ord_re;
    spq_pkg::t_idx               ord_waddr, ord_raddr;
    spq_pkg::t_ord_entry         ord_wdata, ord_q;
    logic [$bits(spq_pkg::t_ord_entry)-1:0] ord_rdata;
    logic                        slot_we, slot_re;
    spq_pkg::t_idx               slot_waddr, slot_raddr;
    spq_pkg::t_slot_entry        slot_wdata, slot_q;
    logic [$bits(spq_pkg::t_slot_entry)-1:0] slot_rdata;

    spq_pkg::t_idx               tail;
    spq_pkg::t_idx               ret_idx;
    logic                        ret_ok;
    logic                        issue;
    spq_pkg::t_time              add_trig;
    spq_pkg::t_time              poll_trig;

    // Saturating sum of a time and a period.
    function automatic spq_pkg::t_time sat_add(spq_pkg::t_time a, spq_pkg::t_period b);
        logic [spq_pkg::TIME_BITS:0] s;
        s = {1'b0, a} + (spq_pkg::TIME_BITS + 1)'(b);
        return s[spq_pkg::TIME_BITS] ? '1 : s[spq_pkg::TIME_BITS-1:0];
    endfunction

    // Step back one place in the circular list.
    function automatic spq_pkg::t_idx dec_idx(spq_pkg::t_idx x);
        return (x == '0) ? LAST_IDX : x - 1'b1;
    endfunction

    // Step forward one place in the circular list.
    function automatic spq_pkg::t_idx inc_idx(spq_pkg::t_idx x);
        return (x == LAST_IDX) ? '0 : x + 1'b1;
    endfunction

    // Sorted list of queued timers, each with its trigger time.
    spq_ram #(
        .WIDTH ($bits(spq_pkg::t_ord_entry)),
        .DEPTH (spq_pkg::TIMERS)
    ) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_re    (ord_re),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // Period and next trigger of every slot.
    spq_ram #(
        .WIDTH ($bits(spq_pkg::t_slot_entry)),
        .DEPTH (spq_pkg::TIMERS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    assign ord_q  = spq_pkg::t_ord_entry'(ord_rdata);
    assign slot_q = spq_pkg::t_slot_entry'(slot_rdata);

    // Physical place just past the last queued entry.
    always_comb begin
        logic [spq_pkg::LEN_BITS:0] s;
        s = (spq_pkg::LEN_BITS + 1)'(r_head) + (spq_pkg::LEN_BITS + 1)'(r_len);
        if (s >= (spq_pkg::LEN_BITS + 1)'(spq_pkg::TIMERS)) begin
            s = s - (spq_pkg::LEN_BITS + 1)'(spq_pkg::TIMERS);
        end
        tail = spq_pkg::IDX_BITS'(s);
    end

    assign ret_idx   = spq_pkg::IDX_BITS'(r_item.handle);
    assign ret_ok    = (int'(r_item.handle) < spq_pkg::TIMERS) && r_out[ret_idx];
    assign issue     = (r_rcnt != '0);
    assign add_trig  = sat_add(r_item.now_ms, r_item.interval_ms);
    assign poll_trig = sat_add(r_item.now_ms, slot_q.period);

    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = (r_state == S_DONE);
    assign o_res        = r_res;

    // Next-state logic and memory accesses.
    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_len   = r_len;
        n_head  = r_head;
        n_busy  = r_busy;
        n_out   = r_out;
        n_idx   = r_idx;
        n_t     = r_t;
        n_slot  = r_slot;
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_rcnt  = r_rcnt;
        n_dv    = 1'b0;
        n_res   = r_res;

        ord_we     = 1'b0;
        ord_waddr  = r_wp;
        ord_wdata  = ord_q;
        ord_re     = 1'b0;
        ord_raddr  = r_rp;
        slot_we    = 1'b0;
        slot_waddr = r_slot;
        slot_wdata = slot_q;
        slot_re    = 1'b0;
        slot_raddr = ret_idx;

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_item  = i_item;
                    n_state = S_DISP;
                end
            end

            S_DISP: begin
                unique case (r_item.action)
                    spq_pkg::ACT_ADD: begin
                        if (r_item.interval_ms < i_min_interval) begin
                            n_res   = '{status: spq_pkg::ST_TOO_SMALL, handle_out: '0};
                            n_state = S_DONE;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end
                    spq_pkg::ACT_POLL: begin
                        if (r_len == '0) begin
                            n_res   = '{status: spq_pkg::ST_NOT_DUE, handle_out: '0};
                            n_state = S_DONE;
                        end else begin
                            ord_re    = 1'b1;
                            ord_raddr = r_head;
                            n_state   = S_POLL1;
                        end
                    end
                    spq_pkg::ACT_RETURN: begin
                        if (!ret_ok) begin
                            n_res   = '{status: spq_pkg::ST_NOT_OUT, handle_out: '0};
                            n_state = S_DONE;
                        end else if (r_item.finished) begin
                            n_out[ret_idx]  = 1'b0;
                            n_busy[ret_idx] = 1'b0;
                            n_res   = '{status: spq_pkg::ST_OK, handle_out: '0};
                            n_state = S_DONE;
                        end else begin
                            slot_re    = 1'b1;
                            slot_raddr = ret_idx;
                            n_state    = S_RET;
                        end
                    end
                    spq_pkg::ACT_CLEAR: begin
                        n_len   = '0;
                        n_busy  = '0;
                        n_out   = '0;
                        n_res   = '{status: spq_pkg::ST_OK, handle_out: '0};
                        n_state = S_DONE;
                    end
                    default: n_state = S_DONE;
                endcase
            end

            // Look for the lowest free slot, one slot per cycle.
            S_SCAN: begin
                if (!r_busy[r_idx]) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_idx;
                    slot_wdata = '{period: r_item.interval_ms, trig: add_trig};
                    n_t        = add_trig;
                    n_slot     = r_idx;
                    n_res      = '{status: spq_pkg::ST_OK,
                                   handle_out: spq_pkg::HANDLE_BITS'(r_idx)};
                    n_wp       = tail;
                    n_rp       = dec_idx(tail);
                    n_rcnt     = r_len;
                    n_state    = S_WALK;
                end else if (r_idx == LAST_IDX) begin
                    n_res   = '{status: spq_pkg::ST_FULL, handle_out: '0};
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // Head entry is back: fire it if due, then fetch its period.
            S_POLL1: begin
                if (ord_q.trig > r_item.now_ms) begin
                    n_res   = '{status: spq_pkg::ST_NOT_DUE, handle_out: '0};
                    n_state = S_DONE;
                end else begin
                    n_slot     = ord_q.slot;
                    slot_re    = 1'b1;
                    slot_raddr = ord_q.slot;
                    n_state    = S_POLL2;
                end
            end

            // Pop the head and rearm the slot.
            S_POLL2: begin
                slot_we       = 1'b1;
                slot_waddr    = r_slot;
                slot_wdata    = '{period: slot_q.period, trig: poll_trig};
                n_head        = inc_idx(r_head);
                n_len         = r_len - 1'b1;
                n_out[r_slot] = 1'b1;
                n_res         = '{status: spq_pkg::ST_OK,
                                  handle_out: spq_pkg::HANDLE_BITS'(r_slot)};
                n_state       = S_DONE;
            end

            // Trigger time of the returned timer is back: start reinsertion.
            S_RET: begin
                n_t     = slot_q.trig;
                n_slot  = ret_idx;
                n_res   = '{status: spq_pkg::ST_OK, handle_out: '0};
                n_wp    = tail;
                n_rp    = dec_idx(tail);
                n_rcnt  = r_len;
                n_state = S_WALK;
            end

            // Walk from the tail toward the head, moving later entries up by one.
            S_WALK: begin
                if (issue) begin
                    ord_re    = 1'b1;
                    ord_raddr = r_rp;
                    n_rp      = dec_idx(r_rp);
                    n_rcnt    = r_rcnt - 1'b1;
                end
                n_dv = issue;
                if (r_dv && (ord_q.trig > r_t)) begin
                    ord_we    = 1'b1;
                    ord_waddr = r_wp;
                    ord_wdata = ord_q;
                    n_wp      = dec_idx(r_wp);
                end else if (r_dv || !issue) begin
                    ord_we         = 1'b1;
                    ord_waddr      = r_wp;
                    ord_wdata      = '{trig: r_t, slot: r_slot};
                    n_len          = r_len + 1'b1;
                    n_busy[r_slot] = 1'b1;
                    n_out[r_slot]  = 1'b0;
                    n_dv           = 1'b0;
                    n_state        = S_DONE;
                end
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_head  <= '0;
            r_busy  <= '0;
            r_out   <= '0;
            r_rcnt  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_head  <= n_head;
            r_busy  <= n_busy;
            r_out   <= n_out;
            r_rcnt  <= n_rcnt;
            r_dv    <= n_dv;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        r_t    <= n_t;
        r_slot <= n_slot;
        r_wp   <= n_wp;
        r_rp   <= n_rp;
        r_res  <= n_res;
    end

endmodule

// ===== design/spq_checker.sv =====
// Port-level checker of the timer queue and its binding to the top level.
`include "sorted_periodic_timer_queue_top_assert.svh"

module spq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [spq_pkg::STATUS_BITS-1:0] m_axis_tuser
);

    logic                                                 status_known;
    logic                                                 res_failed;
    logic                                                 handle_zero;
    logic                                                 in_xfer;
    logic                                                 out_stall;
    logic [spq_pkg::OUT_TDATA_W+spq_pkg::STATUS_BITS:0]   out_beat;

    // Conditions watched by the assertions below.
    assign status_known = (m_axis_tuser <= spq_pkg::ST_NOT_OUT);
    assign res_failed   = m_axis_tvalid && (m_axis_tuser != spq_pkg::ST_OK);
    assign handle_zero  = (m_axis_tdata == '0);
    assign in_xfer      = s_axis_tvalid && s_axis_tready;
    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_beat     = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

    // Every status carries one of the defined codes.
    `SPQ_ASSERT_SAME(a_status, i_clk, i_rst_n, m_axis_tvalid, status_known, "bad status")

    // A failed request never names a slot.
    `SPQ_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n, res_failed, handle_zero, "handle on failure")

    // Requests are processed one at a time.
    `SPQ_ASSERT_NEXT(a_single_req, i_clk, i_rst_n, in_xfer, !s_axis_tready, "taken while busy")

    // A stalled result holds with its valid.
    `SPQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_stall, $stable(out_beat), "result changed")

endmodule

bind sorted_periodic_timer_queue_top spq_checker u_spq_checker (.*);
